// File: src/ptd_pkg.sv
// shared types, codes and microcode table for the trial-division primality tester
// no dependencies
package ptd_pkg;

    localparam int PTD_DATA_WIDTH = 32;

    // sequencer step addresses
    localparam logic [2:0] STEP_FETCH  = 3'd0;
    localparam logic [2:0] STEP_SMALL  = 3'd1;
    localparam logic [2:0] STEP_SQ     = 3'd2;
    localparam logic [2:0] STEP_DIV    = 3'd3;
    localparam logic [2:0] STEP_CHKREM = 3'd4;
    localparam logic [2:0] STEP_EMIT   = 3'd5;

    // branch conditions
    localparam logic [2:0] COND_IN_VALID = 3'd0;
    localparam logic [2:0] COND_SMALL_NP = 3'd1;
    localparam logic [2:0] COND_SQ_GT    = 3'd2;
    localparam logic [2:0] COND_DIV_LAST = 3'd3;
    localparam logic [2:0] COND_REM_ZERO = 3'd4;
    localparam logic [2:0] COND_OUT_FREE = 3'd5;

    // datapath operations
    localparam logic [2:0] OP_NONE     = 3'd0;
    localparam logic [2:0] OP_LOAD     = 3'd1;
    localparam logic [2:0] OP_RES0     = 3'd2;
    localparam logic [2:0] OP_RES1     = 3'd3;
    localparam logic [2:0] OP_DIV_INIT = 3'd4;
    localparam logic [2:0] OP_DIV_STEP = 3'd5;
    localparam logic [2:0] OP_NEXT_D   = 3'd6;
    localparam logic [2:0] OP_EMIT     = 3'd7;

    typedef struct packed {
        logic [2:0] cond;
        logic [2:0] tgt_t;
        logic [2:0] tgt_f;
        logic [2:0] op_t;
        logic [2:0] op_f;
    } t_uword;

    typedef struct packed {
        logic [2:0] op;
        logic       idle;
    } t_dp_ctrl;

    typedef struct packed {
        logic in_valid;
        logic small_np;
        logic sq_gt;
        logic div_last;
        logic rem_zero;
        logic out_free;
    } t_dp_status;

    function automatic t_uword ptd_ucode(input logic [2:0] step);
        t_uword w;
        unique case (step)
            STEP_FETCH:  w = '{COND_IN_VALID, STEP_SMALL, STEP_FETCH,  OP_LOAD,     OP_NONE};
            STEP_SMALL:  w = '{COND_SMALL_NP, STEP_EMIT,  STEP_SQ,     OP_RES0,     OP_NONE};
            STEP_SQ:     w = '{COND_SQ_GT,    STEP_EMIT,  STEP_DIV,    OP_RES1,     OP_DIV_INIT};
            STEP_DIV:    w = '{COND_DIV_LAST, STEP_CHKREM, STEP_DIV,   OP_DIV_STEP, OP_DIV_STEP};
            STEP_CHKREM: w = '{COND_REM_ZERO, STEP_EMIT,  STEP_SQ,     OP_RES0,     OP_NEXT_D};
            STEP_EMIT:   w = '{COND_OUT_FREE, STEP_FETCH, STEP_EMIT,   OP_EMIT,     OP_NONE};
            default:     w = '{COND_IN_VALID, STEP_FETCH, STEP_FETCH,  OP_NONE,     OP_NONE};
        endcase
        return w;
    endfunction

endpackage

// File: src/ptd_sequencer.sv
// microcode sequencer: step counter, control word lookup and conditional jumps
// depends on ptd_pkg
module ptd_sequencer
    import ptd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_status i_status,
    output t_dp_ctrl   o_ctrl
);

    logic [2:0] r_pc;
    logic [2:0] n_pc;
    t_uword     uw;
    logic       cond_true;

    assign uw = ptd_ucode(r_pc);

    always_comb begin
        unique case (uw.cond)
            COND_IN_VALID: cond_true = i_status.in_valid;
            COND_SMALL_NP: cond_true = i_status.small_np;
            COND_SQ_GT:    cond_true = i_status.sq_gt;
            COND_DIV_LAST: cond_true = i_status.div_last;
            COND_REM_ZERO: cond_true = i_status.rem_zero;
            COND_OUT_FREE: cond_true = i_status.out_free;
            default:       cond_true = 1'b0;
        endcase
    end

    assign n_pc        = cond_true ? uw.tgt_t : uw.tgt_f;
    assign o_ctrl.op   = cond_true ? uw.op_t : uw.op_f;
    assign o_ctrl.idle = (r_pc == STEP_FETCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    a_pc_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= STEP_EMIT)
        else $error("sequencer step out of program");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == STEP_DIV) |=> (r_pc == STEP_DIV || r_pc == STEP_CHKREM))
        else $error("division loop left to wrong step");

endmodule

// File: src/ptd_datapath.sv
// datapath: operand, divisor, square, bit-serial remainder and output register
// depends on ptd_pkg
module ptd_datapath
    import ptd_pkg::*;
#(
    parameter int DATA_WIDTH = PTD_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_ctrl              i_ctrl,
    output t_dp_status            o_status,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [DATA_WIDTH-1:0] i_number,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_is_prime
);

    localparam int CW = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] r_n;
    logic [DATA_WIDTH-1:0] r_d;
    logic [DATA_WIDTH:0]   r_sq;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [CW-1:0]         r_cnt;
    logic                  r_result;
    logic                  r_out_valid;
    logic                  r_is_prime;

    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH:0]   d_ext;
    logic                  rem_ge;

    // one restoring-division bit per cycle, msb of n first
    assign rem_sh = {r_rem, r_n[r_cnt]};
    assign d_ext  = {1'b0, r_d};
    assign rem_ge = (rem_sh >= d_ext);

    assign o_status.in_valid = i_valid;
    assign o_status.small_np = r_n[DATA_WIDTH-1] || (r_n <= DATA_WIDTH'(1));
    assign o_status.sq_gt    = (r_sq > {1'b0, r_n});
    assign o_status.div_last = (r_cnt == '0);
    assign o_status.rem_zero = (r_rem == '0);
    assign o_status.out_free = !r_out_valid || !i_stall;

    assign o_stall    = !i_ctrl.idle;
    assign o_valid    = r_out_valid;
    assign o_is_prime = r_is_prime;

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            OP_LOAD: begin
                r_n  <= i_number;
                r_d  <= DATA_WIDTH'(2);
                r_sq <= (DATA_WIDTH + 1)'(4);
            end
            OP_RES0: r_result <= 1'b0;
            OP_RES1: r_result <= 1'b1;
            OP_DIV_INIT: begin
                r_rem <= '0;
                r_cnt <= CW'(DATA_WIDTH - 1);
            end
            OP_DIV_STEP: begin
                r_rem <= rem_ge ? DATA_WIDTH'(rem_sh - d_ext) : DATA_WIDTH'(rem_sh);
                r_cnt <= r_cnt - CW'(1);
            end
            OP_NEXT_D: begin
                // (d+1)^2 = d^2 + 2d + 1
                r_d  <= r_d + DATA_WIDTH'(1);
                r_sq <= r_sq + {r_d, 1'b1};
            end
            OP_EMIT: r_is_prime <= r_result;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    a_load_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_LOAD) |=> (r_d == DATA_WIDTH'(2)) && (r_sq == (DATA_WIDTH + 1)'(4)))
        else $error("divisor not initialized on load");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_EMIT) |=> o_valid)
        else $error("result not presented after emit");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_DIV_STEP) |=> (r_rem < r_d))
        else $error("partial remainder not below divisor");

endmodule

// File: src/prime_trial_division_top.sv
// primality test by trial division, one transaction in, one result out
// values not above 1 or with the msb set are reported not prime without a division; two and
// three pass the first square test, others try divisors from 2 up while d*d <= n; each divisor costs one bit-serial
// remainder of DATA_WIDTH steps; one item
// in flight at a time, the next is accepted while the previous result waits in the output register
// reset returns the sequencer to fetch and empties the output register
module prime_trial_division_top
    import ptd_pkg::*;
#(
    parameter int DATA_WIDTH = PTD_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [DATA_WIDTH-1:0] i_number,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_is_prime
);

    t_dp_ctrl   ctrl;
    t_dp_status status;

    ptd_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    ptd_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .o_status   (status),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_number   (i_number),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_is_prime (o_is_prime)
    );

endmodule
